// File: rtl/mwalu_pkg.sv
// mwalu_pkg: shared types, constants and a helper function of the multiword integer alu
// used by mwalu_core, mwalu_outq and multiword_integer_alu; depends on nothing
`default_nettype none

package mwalu_pkg;

	localparam int WORD_W    = 32;
	localparam int SHIFT_W   = 5;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int MAX_WORDS = 64;
	localparam int POS_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LEN_W     = $clog2(WORD_W + 1);
	localparam int IN_DATA_W  = ((2 * WORD_W + SHIFT_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((WORD_W + STATUS_W + 7) / 8) * 8;
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_IDX_W  = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
	localparam logic [OP_W-1:0] OP_CMP    = 3'd2;
	localparam logic [OP_W-1:0] OP_SHIFT  = 3'd3;
	localparam logic [OP_W-1:0] OP_BITCNT = 3'd4;

	localparam logic [STATUS_W-1:0] CMP_EQUAL   = 2'd0;
	localparam logic [STATUS_W-1:0] CMP_LARGER  = 2'd1;
	localparam logic [STATUS_W-1:0] CMP_SMALLER = 2'd2;

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_WORDS - 1);

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [WORD_W-1:0]  a_word;
		logic [WORD_W-1:0]  b_word;
		logic [SHIFT_W-1:0] shift_bits;
		logic               last_in;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]   out_word;
		logic [STATUS_W-1:0] status;
		logic                last_out;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} core_out_t;

	function automatic logic [LEN_W-1:0] bit_length(input logic [WORD_W-1:0] w);
		logic [LEN_W-1:0] len;
		len = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				len = LEN_W'(i + 1);
			end
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mwalu_core.sv
// mwalu_core: per-word arithmetic, compare, funnel shift and bit length with running state
// imports mwalu_pkg; results are combinational from the input stage register
`default_nettype none

module mwalu_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire mwalu_pkg::item_t item,
	input  wire                  advance,
	output mwalu_pkg::core_out_t core_out
);
	import mwalu_pkg::*;

	logic                carry_q;
	logic [STATUS_W-1:0] cmp_q;
	logic [WORD_W-1:0]   prev_word_q;
	logic                have_prev_q;
	logic [POS_W-1:0]    pos_q;
	logic                top_valid_q;
	logic [POS_W-1:0]    top_pos_q;
	logic [LEN_W-1:0]    top_len_q;

	logic [WORD_W:0]     sum;
	logic [WORD_W:0]     diff;
	logic [STATUS_W-1:0] cmp_next;
	logic [WORD_W-1:0]   pair_word;
	logic [WORD_W-1:0]   top_word;
	logic [LEN_W-1:0]    a_len;
	logic                a_nz;
	logic                cnt_valid;
	logic [POS_W-1:0]    cnt_pos;
	logic [LEN_W-1:0]    cnt_len;
	logic [WORD_W-1:0]   count;
	logic [2*WORD_W-1:0] funnel;

	assign sum  = {1'b0, item.a_word} + {1'b0, item.b_word} + (WORD_W+1)'(carry_q);
	assign diff = {1'b0, item.a_word} - {1'b0, item.b_word} - (WORD_W+1)'(carry_q);
	assign funnel    = {item.a_word, prev_word_q} >> item.shift_bits;
	assign pair_word = funnel[WORD_W-1:0];
	assign top_word  = item.a_word >> item.shift_bits;
	assign a_len = bit_length(item.a_word);
	assign a_nz  = (item.a_word != '0);
	assign cnt_valid = a_nz | top_valid_q;
	assign cnt_pos   = a_nz ? pos_q : top_pos_q;
	assign cnt_len   = a_nz ? a_len : top_len_q;
	assign count = cnt_valid ? (WORD_W'({cnt_pos, 5'd0}) + WORD_W'(cnt_len)) : '0;

	always_comb begin
		if (item.a_word > item.b_word) begin
			cmp_next = CMP_LARGER;
		end else if (item.a_word < item.b_word) begin
			cmp_next = CMP_SMALLER;
		end else begin
			cmp_next = cmp_q;
		end
	end

	always_comb begin
		core_out = '0;
		case (item.op)
			OP_ADD: begin
				core_out.n = 2'd1;
				core_out.res0 = '{sum[WORD_W-1:0],
					item.last_in ? STATUS_W'(sum[WORD_W]) : '0, item.last_in};
			end
			OP_SUB: begin
				core_out.n = 2'd1;
				core_out.res0 = '{diff[WORD_W-1:0],
					item.last_in ? STATUS_W'(diff[WORD_W]) : '0, item.last_in};
			end
			OP_CMP: begin
				if (item.last_in) begin
					core_out.n = 2'd1;
					core_out.res0 = '{'0, cmp_next, 1'b1};
				end
			end
			OP_SHIFT: begin
				if (have_prev_q) begin
					core_out.res0 = '{pair_word, '0, 1'b0};
					core_out.res1 = '{top_word, '0, 1'b1};
					core_out.n = item.last_in ? 2'd2 : 2'd1;
				end else if (item.last_in) begin
					core_out.n = 2'd1;
					core_out.res0 = '{top_word, '0, 1'b1};
				end
			end
			OP_BITCNT: begin
				if (item.last_in) begin
					core_out.n = 2'd1;
					core_out.res0 = '{count, '0, 1'b1};
				end
			end
			default: begin
				core_out = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= 1'b0;
			cmp_q       <= CMP_EQUAL;
			prev_word_q <= '0;
			have_prev_q <= 1'b0;
			pos_q       <= '0;
			top_valid_q <= 1'b0;
			top_pos_q   <= '0;
			top_len_q   <= '0;
		end else if (advance) begin
			if (item.last_in) begin
				carry_q     <= 1'b0;
				cmp_q       <= CMP_EQUAL;
				prev_word_q <= '0;
				have_prev_q <= 1'b0;
				pos_q       <= '0;
				top_valid_q <= 1'b0;
				top_pos_q   <= '0;
				top_len_q   <= '0;
			end else begin
				case (item.op)
					OP_ADD: begin
						carry_q <= sum[WORD_W];
					end
					OP_SUB: begin
						carry_q <= diff[WORD_W];
					end
					OP_CMP: begin
						cmp_q <= cmp_next;
					end
					OP_SHIFT: begin
						prev_word_q <= item.a_word;
						have_prev_q <= 1'b1;
					end
					OP_BITCNT: begin
						if (a_nz) begin
							top_valid_q <= 1'b1;
							top_pos_q   <= pos_q;
							top_len_q   <= a_len;
						end
					end
					default: begin
					end
				endcase
				if ((item.op <= OP_BITCNT) && (pos_q < POS_LIMIT)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/mwalu_outq.sv
// mwalu_outq: small result queue taking up to two results per cycle, one out per cycle
// while ready; imports mwalu_pkg; feeds the master stream of multiword_integer_alu
`default_nettype none

module mwalu_outq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  wire mwalu_pkg::core_out_t    core_out,
	output logic                         room2,
	output logic [mwalu_pkg::OQ_CNT_W-1:0] count,
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [mwalu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                         m_axis_tlast
);
	import mwalu_pkg::*;

	result_t              entry_q [OQ_DEPTH];
	logic [OQ_IDX_W-1:0]  wr_ptr_q;
	logic [OQ_IDX_W-1:0]  rd_ptr_q;
	logic [OQ_CNT_W-1:0]  count_q;
	logic                 pop;
	logic [1:0]           n_push;
	result_t              head;

	assign pop    = m_axis_tvalid && m_axis_tready;
	assign n_push = push ? core_out.n : 2'd0;
	assign room2  = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign count  = count_q;
	assign head   = entry_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = OUT_DATA_W'({head.status, head.out_word});
	assign m_axis_tlast  = head.last_out;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entry_q[wr_ptr_q] <= core_out.res0;
		end
		if (n_push == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= core_out.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_IDX_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQ_CNT_W'(n_push) - OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/multiword_integer_alu.sv
// channel  dir  tdata (low bit up)                     tuser  tlast
// s_axis   in   a_word[31:0] b_word[31:0] shift_bits[4:0] op     last_in
// m_axis   out  out_word[31:0] status[1:0]               -      last_out
// one request per cycle unless stalled: input register -> core -> result queue
// results go valid at the edge that moves the request out of the input register
// a shift request that ends an operation after earlier shift words gives two results
// the input register holds while the result queue has fewer than two free entries
// arst_n clears the running state, the input register valid and the queue
// multiword_integer_alu: top level; depends on mwalu_pkg, mwalu_core, mwalu_outq
`default_nettype none

module multiword_integer_alu (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [mwalu_pkg::IN_DATA_W-1:0]  s_axis_tdata, // a_word, b_word, shift_bits
	input  wire  [mwalu_pkg::OP_W-1:0]       s_axis_tuser, // op
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [mwalu_pkg::OUT_DATA_W-1:0] m_axis_tdata, // out_word, status
	output logic        m_axis_tlast
);
	import mwalu_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic                advance_s1;
	logic                room2;
	logic [OQ_CNT_W-1:0] q_count;
	core_out_t           core_out;

	assign advance_s1    = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op         <= s_axis_tuser;
			item_s1.a_word     <= s_axis_tdata[WORD_W-1:0];
			item_s1.b_word     <= s_axis_tdata[2*WORD_W-1:WORD_W];
			item_s1.shift_bits <= s_axis_tdata[2*WORD_W+SHIFT_W-1:2*WORD_W];
			item_s1.last_in    <= s_axis_tlast;
		end
	end

	mwalu_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.advance  (advance_s1),
		.core_out (core_out)
	);

	mwalu_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (advance_s1),
		.core_out      (core_out),
		.room2         (room2),
		.count         (q_count),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue overflow");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register changed while stalled");

	a_two_only_shift_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && core_out.n == 2'd2) |-> (item_s1.op == OP_SHIFT && item_s1.last_in))
		else $error("two results outside a closing shift");

	a_no_three: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (core_out.n != 2'd3))
		else $error("invalid result count");

endmodule

`default_nettype wire
